// File: hdl/qalu_pkg.sv
// qalu_pkg: shared types for the quaternion ALU.
// Holds the operation codes carried in tuser; files reach it through scoped names.
// No dependencies.
package qalu_pkg;

	// operation selector carried on s_tuser
	typedef enum logic [2:0] {
		OP_MUL   = 3'd0,
		OP_ADD   = 3'd1,
		OP_SUB   = 3'd2,
		OP_SCALE = 3'd3,
		OP_NEG   = 3'd4,
		OP_CONJ  = 3'd5,
		OP_DOT   = 3'd6,
		OP_ROT   = 3'd7
	} op_t;

endpackage

// File: hdl/quaternion_alu.sv
// Quaternion ALU, fixed point, four-stage pipeline.
// Throughput: one word per cycle while m_tready keeps the output draining; the output handshake sets the pace.
// A stalled output holds its word; bubbles collapse, so ready only drops when all stages are full.
// Reset (arst_n low) clears the stage valid bits only; data registers are not reset.
module quaternion_alu #(
	parameter int FRAC_BITS = 12,
	parameter int WORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale (lowest first), zero padded
	input  logic [((9*WORD_BITS+7)/8)*8-1:0]      s_tdata,
	// op
	input  logic [2:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// r_x, r_y, r_z, r_w (lowest first), zero padded
	output logic [((4*WORD_BITS+7)/8)*8-1:0]      m_tdata
);

	localparam int W     = WORD_BITS;
	localparam int CW    = W + 1;
	localparam int TW    = W + 4;
	localparam int OBITS = ((4*W+7)/8)*8;
	localparam int ACC1  = (2*W + 2 > 64) ? 64 : 2*W + 2;
	localparam int ACC2  = (2*W + 7 > 64) ? 64 : 2*W + 7;

	// stage control
	logic                   vld_s1, vld_s2, vld_s3;
	logic                   en_s1, en_s2, en_s3, en_s4;

	// stage registers
	qalu_pkg::op_t          op_s1;
	logic signed [W-1:0]    a_s1   [4];
	logic signed [W-1:0]    res_s1 [4];
	logic signed [W-1:0]    res_s2 [4];
	logic signed [TW-1:0]   t_s2   [4];
	logic signed [CW-1:0]   c_s2   [4];
	logic                   rot_s2;
	logic signed [W-1:0]    res_s3 [4];
	logic                   rot_s3;
	logic signed [W-1:0]    out_s4 [4];

	// input decode
	qalu_pkg::op_t          op_in;
	logic signed [W-1:0]    a_in   [4];
	logic signed [W-1:0]    b_raw  [4];
	logic signed [W-1:0]    b_sel  [4];
	logic signed [W-1:0]    scl_in;
	logic signed [CW-1:0]   simple [4];
	logic signed [W-1:0]    simple_sat [4];
	logic signed [W-1:0]    res1_d [4];

	// stage 2 and 4 combinational
	logic signed [2*W-1:0]  p1 [4][4];
	logic signed [ACC1-1:0] hs1 [4];
	logic signed [ACC1-1:0] ds1;
	logic signed [W-1:0]    hsat [4];
	logic signed [W-1:0]    dsat;
	logic signed [W-1:0]    res2_d [4];
	logic signed [TW+CW-1:0] p2 [4][4];
	logic signed [ACC2-1:0] hs2 [4];
	logic signed [ACC2-1:0] ds2;
	logic signed [W-1:0]    rsat [3];

	// ready chain: a stage moves when it is empty or the next one moves
	always_comb begin
		en_s4 = !m_tvalid || m_tready;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end
	assign s_tready = en_s1;

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) m_tvalid <= vld_s3;
		end
	end

	// unpack the input word
	always_comb begin
		op_in = qalu_pkg::op_t'(s_tuser);
		for (int i = 0; i < 4; i++) begin
			a_in[i]  = s_tdata[i*W +: W];
			b_raw[i] = s_tdata[(4+i)*W +: W];
		end
		scl_in = s_tdata[8*W +: W];
	end

	// pick the B operand: scale multiplies by (0,0,0,s), rotate drops b_w
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			b_sel[i] = b_raw[i];
		end
		case (op_in)
			qalu_pkg::OP_SCALE: begin
				b_sel[0] = '0;
				b_sel[1] = '0;
				b_sel[2] = '0;
				b_sel[3] = scl_in;
			end
			qalu_pkg::OP_ROT: begin
				b_sel[3] = '0;
			end
			default: begin
			end
		endcase
	end

	// add, subtract, negate at one extra bit
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			case (op_in)
				qalu_pkg::OP_ADD: simple[i] = CW'(a_in[i]) + CW'(b_raw[i]);
				qalu_pkg::OP_SUB: simple[i] = CW'(a_in[i]) - CW'(b_raw[i]);
				default:          simple[i] = -CW'(a_in[i]);
			endcase
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_simple_sat
		qalu_sat #(.IW(CW), .OW(W)) u_sat (.x(simple[g]), .y(simple_sat[g]));
	end

	// conjugate passes w through untouched
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res1_d[i] = simple_sat[i];
		end
		if (op_in == qalu_pkg::OP_CONJ) begin
			res1_d[3] = a_in[3];
		end
	end

	// stage 1: cross products of A and B
	qalu_hprod #(.WA(W), .WB(W)) u_hprod1 (
		.clk  (clk),
		.en   (en_s1),
		.a    (a_in),
		.b    (b_sel),
		.prod (p1)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= op_in;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]   <= a_in[i];
				res_s1[i] <= res1_d[i];
			end
		end
	end

	// stage 2: sum, shift, saturate
	qalu_hsum #(.PW(2*W), .ACCW(ACC1), .FRAC(FRAC_BITS)) u_hsum1 (
		.prod (p1),
		.hs   (hs1),
		.ds   (ds1)
	);

	for (genvar g = 0; g < 4; g++) begin : g_hsat
		qalu_sat #(.IW(ACC1), .OW(W)) u_sat (.x(hs1[g]), .y(hsat[g]));
	end
	qalu_sat #(.IW(ACC1), .OW(W)) u_dsat (.x(ds1), .y(dsat));

	// select the finished result for everything but rotate
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res2_d[i] = res_s1[i];
		end
		case (op_s1) inside
			qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					res2_d[i] = hsat[i];
				end
			end
			qalu_pkg::OP_DOT: begin
				res2_d[0] = '0;
				res2_d[1] = '0;
				res2_d[2] = '0;
				res2_d[3] = dsat;
			end
			default: begin
			end
		endcase
	end

	// keep the wrapped intermediate and the conjugate of A for rotate
	always_ff @(posedge clk) begin
		if (en_s2) begin
			rot_s2 <= (op_s1 == qalu_pkg::OP_ROT);
			for (int i = 0; i < 4; i++) begin
				res_s2[i] <= res2_d[i];
				t_s2[i]   <= hs1[i][TW-1:0];
			end
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= -CW'(a_s1[i]);
			end
			c_s2[3] <= CW'(a_s1[3]);
		end
	end

	// stage 3: cross products of the intermediate and conj(A)
	qalu_hprod #(.WA(TW), .WB(CW)) u_hprod2 (
		.clk  (clk),
		.en   (en_s3),
		.a    (t_s2),
		.b    (c_s2),
		.prod (p2)
	);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rot_s3 <= rot_s2;
			for (int i = 0; i < 4; i++) begin
				res_s3[i] <= res_s2[i];
			end
		end
	end

	// stage 4: finish rotate and load the output register
	qalu_hsum #(.PW(TW+CW), .ACCW(ACC2), .FRAC(FRAC_BITS)) u_hsum2 (
		.prod (p2),
		.hs   (hs2),
		.ds   (ds2)
	);

	for (genvar g = 0; g < 3; g++) begin : g_rsat
		qalu_sat #(.IW(ACC2), .OW(W)) u_sat (.x(hs2[g]), .y(rsat[g]));
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (rot_s3) begin
				out_s4[0] <= rsat[0];
				out_s4[1] <= rsat[1];
				out_s4[2] <= rsat[2];
				out_s4[3] <= '0;
			end else begin
				for (int i = 0; i < 4; i++) begin
					out_s4[i] <= res_s3[i];
				end
			end
		end
	end

	assign m_tdata = OBITS'({out_s4[3], out_s4[2], out_s4[1], out_s4[0]});

	// a rotate word leaves with w cleared
	a_rot_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && rot_s3 && en_s4 |=> out_s4[3] == '0)
		else $error("rotate result w not zero");

	// with every stage full and the output stalled, input must wait
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && vld_s3 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted into a full pipeline");

	// a blocked stage keeps its word
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !en_s3 |=> vld_s3 && $stable(rot_s3))
		else $error("stage 3 word lost while blocked");

	// an empty pipeline always takes input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 && !vld_s2 && !vld_s3 && !m_tvalid |-> s_tready)
		else $error("empty pipeline not ready");

endmodule

// File: hdl/qalu_sat.sv
// qalu_sat: clamps a signed value to a narrower signed range.
// Pure combinational; no dependencies.
module qalu_sat #(
	parameter int IW = 17,
	parameter int OW = 16
) (
	input  logic signed [IW-1:0] x,
	output logic signed [OW-1:0] y
);

	localparam logic signed [IW-1:0] MAXV = {{(IW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [IW-1:0] MINV = {{(IW-OW+1){1'b1}}, {(OW-1){1'b0}}};

	// clamp to the output range
	always_comb begin
		if (x > MAXV) begin
			y = MAXV[OW-1:0];
		end else if (x < MINV) begin
			y = MINV[OW-1:0];
		end else begin
			y = x[OW-1:0];
		end
	end

endmodule

// File: hdl/qalu_hprod.sv
// qalu_hprod: registered array of all sixteen cross products a[i]*b[j].
// One pipeline stage of the Hamilton product; no dependencies.
module qalu_hprod #(
	parameter int WA = 16,
	parameter int WB = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [WA-1:0]        a [4],
	input  logic signed [WB-1:0]        b [4],
	output logic signed [WA+WB-1:0]     prod [4][4]
);

	// capture products when the stage advances
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod[i][j] <= a[i] * b[j];
				end
			end
		end
	end

endmodule

// File: hdl/qalu_hsum.sv
// qalu_hsum: combines registered cross products into Hamilton and dot sums.
// Sums are taken at ACCW bits and shifted right by FRAC toward minus infinity.
// No dependencies.
module qalu_hsum #(
	parameter int PW    = 32,
	parameter int ACCW  = 34,
	parameter int FRAC  = 12
) (
	input  logic signed [PW-1:0]   prod [4][4],
	output logic signed [ACCW-1:0] hs [4],
	output logic signed [ACCW-1:0] ds
);

	logic signed [ACCW-1:0] e [4][4];
	logic signed [ACCW-1:0] h [4];
	logic signed [ACCW-1:0] d;

	// extend or wrap each product to the accumulator width
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e[i][j] = ACCW'(prod[i][j]);
			end
		end
	end

	// Hamilton product sums in x,y,z,w order, plus the dot sum
	always_comb begin
		h[0] = e[3][0] + e[0][3] + e[1][2] - e[2][1];
		h[1] = e[3][1] - e[0][2] + e[1][3] + e[2][0];
		h[2] = e[3][2] + e[0][1] - e[1][0] + e[2][3];
		h[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2];
		d    = e[0][0] + e[1][1] + e[2][2] + e[3][3];
		for (int i = 0; i < 4; i++) begin
			hs[i] = h[i] >>> FRAC;
		end
		ds = d >>> FRAC;
	end

endmodule

// File: tb/sv/quaternion_alu_test.sv
// Self-checking testbench for the quaternion_alu streaming block.
// Drives mixed directed and random words under random stalls, predicts each result in a
// scoreboard class. Depends on qalu_pkg and hdl/quaternion_alu.sv with its qalu_sat, qalu_hprod, qalu_hsum.
module quaternion_alu_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 12;
	localparam int LATENCY = 4;
	localparam int RANDOM_WORDS = 750;

	// one quaternion as it sits in tdata: x in the lowest bits
	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} quat_t;

	// full precision quaternion for the prediction arithmetic
	typedef struct packed {
		logic signed [63:0] w;
		logic signed [63:0] z;
		logic signed [63:0] y;
		logic signed [63:0] x;
	} wide_t;

	localparam logic signed [15:0] MAXV = 16'sh7FFF;
	localparam logic signed [15:0] MINV = -16'sd32768;
	localparam logic signed [15:0] ONE = 16'sd4096;

	class quat_board;
		quat_t expected_quats[$];
		int errors = 0;

		function wide_t widen(quat_t q);
			wide_t r;
			r.x = q.x;
			r.y = q.y;
			r.z = q.z;
			r.w = q.w;
			return r;
		endfunction

		// Hamilton product sums before any shift
		function wide_t hamilton(wide_t a, wide_t b);
			wide_t r;
			r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
			r.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
			r.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
			r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
			return r;
		endfunction

		function logic signed [15:0] clamp16(logic signed [63:0] v);
			if (v > 64'sd32767)
				return MAXV;
			if (v < -64'sd32768)
				return MINV;
			return v[15:0];
		endfunction

		// shift toward minus infinity, then saturate
		function logic signed [15:0] round_sat(logic signed [63:0] v);
			logic signed [63:0] t;
			t = v >>> FRAC;
			return clamp16(t);
		endfunction

		// shift, then keep 20 bits with wraparound
		function logic signed [63:0] round_wrap20(logic signed [63:0] v);
			logic signed [63:0] t;
			logic signed [19:0] n;
			t = v >>> FRAC;
			n = t[19:0];
			return n;
		endfunction

		function quat_t quat_result(qalu_pkg::op_t op, quat_t qa, quat_t qb,
				logic signed [15:0] s);
			wide_t a, b, t, c;
			quat_t r;
			logic signed [63:0] sw;
			a = widen(qa);
			b = widen(qb);
			sw = s;
			r = '0;
			case (op)
				qalu_pkg::OP_MUL: begin
					t = hamilton(a, b);
					r.x = round_sat(t.x);
					r.y = round_sat(t.y);
					r.z = round_sat(t.z);
					r.w = round_sat(t.w);
				end
				qalu_pkg::OP_ADD: begin
					r.x = clamp16(a.x + b.x);
					r.y = clamp16(a.y + b.y);
					r.z = clamp16(a.z + b.z);
					r.w = clamp16(a.w + b.w);
				end
				qalu_pkg::OP_SUB: begin
					r.x = clamp16(a.x - b.x);
					r.y = clamp16(a.y - b.y);
					r.z = clamp16(a.z - b.z);
					r.w = clamp16(a.w - b.w);
				end
				qalu_pkg::OP_SCALE: begin
					r.x = round_sat(a.x * sw);
					r.y = round_sat(a.y * sw);
					r.z = round_sat(a.z * sw);
					r.w = round_sat(a.w * sw);
				end
				qalu_pkg::OP_NEG: begin
					r.x = clamp16(-a.x);
					r.y = clamp16(-a.y);
					r.z = clamp16(-a.z);
					r.w = clamp16(-a.w);
				end
				qalu_pkg::OP_CONJ: begin
					r.x = clamp16(-a.x);
					r.y = clamp16(-a.y);
					r.z = clamp16(-a.z);
					r.w = qa.w;
				end
				qalu_pkg::OP_DOT: begin
					r.w = round_sat(a.x * b.x + a.y * b.y + a.z * b.z + a.w * b.w);
				end
				default: begin
					// A * p * conj(A); the first product wraps instead of saturating
					b.w = 0;
					t = hamilton(a, b);
					t.x = round_wrap20(t.x);
					t.y = round_wrap20(t.y);
					t.z = round_wrap20(t.z);
					t.w = round_wrap20(t.w);
					c.x = -a.x;
					c.y = -a.y;
					c.z = -a.z;
					c.w = a.w;
					t = hamilton(t, c);
					r.x = round_sat(t.x);
					r.y = round_sat(t.y);
					r.z = round_sat(t.z);
				end
			endcase
			return r;
		endfunction

		function void note_input(qalu_pkg::op_t op, quat_t qa, quat_t qb,
				logic signed [15:0] s);
			expected_quats.push_back(quat_result(op, qa, qb, s));
		endfunction

		function void check_result(logic [63:0] data);
			string names[4] = '{"r_x", "r_y", "r_z", "r_w"};
			logic [63:0] want;
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, data);
				errors++;
				return;
			end
			want = expected_quats.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (want[16*i +: 16] !== data[16*i +: 16]) begin
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[i],
						$signed(want[16*i +: 16]), $signed(data[16*i +: 16]));
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale (lowest first)
	logic [143:0] s_tdata = '0;
	// op
	logic [2:0] s_tuser = qalu_pkg::OP_MUL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// r_x, r_y, r_z, r_w (lowest first)
	logic [63:0] m_tdata;

	quat_board board = new();
	bit quiet = 1'b0;

	quaternion_alu uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit roll_idle();
		return !quiet && ($urandom_range(99) < 6);
	endfunction

	function automatic quat_t mkq(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		return '{w: qw, z: qz, y: qy, x: qx};
	endfunction

	// mostly full-range values, with the edges of the range often
	function automatic logic signed [15:0] rand_comp();
		logic signed [15:0] edges[7] = '{MAXV, MINV, 16'sd0, 16'sd1, -16'sd1, ONE, -ONE};
		if ($urandom_range(9) < 3)
			return edges[$urandom_range(6)];
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic quat_t rand_quat();
		return mkq(rand_comp(), rand_comp(), rand_comp(), rand_comp());
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(qalu_pkg::op_t op, quat_t qa, quat_t qb, logic signed [15:0] s);
		while (roll_idle()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s, qb, qa};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_input(op, qa, qb, s);
	endtask

	task automatic wait_drained();
		while (board.expected_quats.size() != 0)
			@(posedge clk);
	endtask

	// take result words and stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			m_tready <= !roll_idle();
		end
	end

	initial begin
		qalu_pkg::op_t op;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edges of every op
		send_word(qalu_pkg::OP_MUL, mkq(MAXV, MAXV, MAXV, MAXV), mkq(MAXV, MAXV, MAXV, MAXV), 0);
		send_word(qalu_pkg::OP_MUL, mkq(MINV, MINV, MINV, MINV), mkq(MINV, MINV, MINV, MINV), 0);
		send_word(qalu_pkg::OP_MUL, mkq(0, 0, 0, ONE), mkq(-1, 1, MAXV, MINV), MAXV);
		send_word(qalu_pkg::OP_ADD, mkq(MAXV, MINV, 1, -1), mkq(MAXV, MINV, -1, 1), 0);
		send_word(qalu_pkg::OP_SUB, mkq(MINV, MAXV, 0, -1), mkq(MAXV, MINV, MINV, MAXV), 0);
		send_word(qalu_pkg::OP_SCALE, mkq(MINV, MAXV, 1, -1), mkq(5, 6, 7, 8), MINV);
		send_word(qalu_pkg::OP_SCALE, mkq(MINV, MAXV, 1, -1), mkq(0, 0, 0, 0), MAXV);
		send_word(qalu_pkg::OP_SCALE, mkq(1, -1, ONE, -ONE), rand_quat(), -1);
		send_word(qalu_pkg::OP_NEG, mkq(MINV, MAXV, 0, MINV), rand_quat(), rand_comp());
		send_word(qalu_pkg::OP_NEG, mkq(-1, 1, MAXV, 0), rand_quat(), rand_comp());
		send_word(qalu_pkg::OP_CONJ, mkq(MINV, MINV, MINV, MINV), rand_quat(), rand_comp());
		send_word(qalu_pkg::OP_CONJ, mkq(MAXV, 1, -1, MAXV), rand_quat(), rand_comp());
		send_word(qalu_pkg::OP_DOT, mkq(MAXV, MAXV, MAXV, MAXV), mkq(MAXV, MAXV, MAXV, MAXV), 0);
		send_word(qalu_pkg::OP_DOT, mkq(MINV, MINV, MINV, MINV), mkq(MINV, MINV, MINV, MINV), 0);
		send_word(qalu_pkg::OP_DOT, mkq(MINV, MAXV, ONE, -1), mkq(MAXV, MAXV, ONE, 1), MINV);
		send_word(qalu_pkg::OP_ROT, mkq(0, 0, 0, ONE), mkq(ONE, -ONE, MAXV, MINV), 0);
		send_word(qalu_pkg::OP_ROT, mkq(MAXV, MAXV, MAXV, MAXV), mkq(MAXV, MINV, MAXV, MAXV), 0);
		send_word(qalu_pkg::OP_ROT, mkq(MINV, MINV, MINV, MINV), mkq(MINV, MINV, MINV, 0), 0);
		send_word(qalu_pkg::OP_ROT, mkq(2896, 0, 0, 2896), mkq(ONE, 0, 0, MAXV), MAXV);

		// random words; one calm stretch and one full drain along the way
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			quiet = (i >= 200 && i < 330);
			if (i == 450) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			op = qalu_pkg::op_t'($urandom_range(7));
			send_word(op, rand_quat(), rand_quat(), rand_comp());
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		// let the pipe empty, then keep waiting for strays
		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (board.errors == 0 && board.expected_quats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#500us;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/qalu_pkg.sv
hdl/qalu_sat.sv
hdl/qalu_hprod.sv
hdl/qalu_hsum.sv
hdl/quaternion_alu.sv
tb/sv/quaternion_alu_test.sv
